[rtl/vta_pkg.sv]
// Shared types, codes and constants of the vector transform unit.
`timescale 1ns / 1ps

package vta_pkg;

	// Default number of fraction bits of the fixed-point format.
	localparam int DEF_FRAC_BITS = 8;

	// Width of the exact sums ahead of scaling and saturation.
	localparam int SUM_W = 34;

	// Width of the sum of three squared components.
	localparam int LEN_W = 32;

	// Width of one squared component.
	localparam int SQ_W = 31;

	// Operation codes.
	typedef enum logic [2:0] {
		OP_TRANSFORM = 3'd0,
		OP_NORMALISE = 3'd1,
		OP_CROSS     = 3'd2,
		OP_DOT       = 3'd3,
		OP_SUB       = 3'd4,
		OP_ADD       = 3'd5
	} op_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_ROW3 = 3'd3
	} reg_idx_t;

	// Identity matrix rows after reset.
	localparam logic [63:0] ROW0_RST = 64'h0000_0000_0000_0100;
	localparam logic [63:0] ROW1_RST = 64'h0000_0000_0100_0000;
	localparam logic [63:0] ROW2_RST = 64'h0000_0100_0000_0000;
	localparam logic [63:0] ROW3_RST = 64'h0100_0000_0000_0000;

	// A saturated component and whether it was clipped.
	typedef struct packed {
		logic [15:0] val;
		logic        ovf;
	} sat_t;

	// Item data carried alongside the normalise search.
	typedef struct packed {
		op_t                        op;
		logic [3:0][15:0]           r;
		logic                       ovf;
		logic [LEN_W-1:0]           len2;
		logic [2:0][SQ_W-1:0]       sq;
		logic [2:0]                 neg;
	} pass_t;

	// Clip a wide signed value into the signed 16-bit range.
	function automatic sat_t sat16(input logic signed [SUM_W-1:0] v);
		sat_t s;
		if (v > SUM_W'(32767)) begin
			s.val = 16'h7fff;
			s.ovf = 1'b1;
		end else if (v < -SUM_W'(32768)) begin
			s.val = 16'h8000;
			s.ovf = 1'b1;
		end else begin
			s.val = v[15:0];
			s.ovf = 1'b0;
		end
		return s;
	endfunction

endpackage

[rtl/vector_transform_alu_unit.sv]
// Top level of the pipelined fixed-point vector transform unit.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// input     | in        | in_valid / in_stall  | operation, a_x..a_w, b_x..b_z
// result    | out       | out_valid / out_stall| r_x..r_w, overflow, zero_length
// config    | in        | cfg_we               | cfg_index, cfg_data
//
// One item enters per cycle while in_stall is low; there are two arithmetic
// stages, FRAC_BITS + 2 normalise search stages of one quotient bit each, and
// the output register. The search is shift-and-add, with no multiplier.
// Reset restores the identity matrix and empties the pipeline.
// A stall on a valid result freezes the whole pipeline and is passed back to in_stall.

module vector_transform_alu_unit #(
	parameter int FRAC_BITS = vta_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         operation,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] a_w,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] r_x,
	output logic signed [15:0] r_y,
	output logic signed [15:0] r_z,
	output logic signed [15:0] r_w,
	output logic               overflow,
	output logic               zero_length,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int NST = FRAC_BITS + 2;          // quotient bits searched
	localparam int MW  = FRAC_BITS + 2;          // quotient width
	localparam int TW  = vta_pkg::LEN_W + MW;    // m * L
	localparam int PW  = vta_pkg::LEN_W + 2 * MW; // m * m * L
	localparam int SW  = vta_pkg::SUM_W;

	// Pipeline advance: everything moves unless a held result is stalled.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Matrix rows.
	logic [63:0] row_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= vta_pkg::ROW0_RST;
			row_q[1] <= vta_pkg::ROW1_RST;
			row_q[2] <= vta_pkg::ROW2_RST;
			row_q[3] <= vta_pkg::ROW3_RST;
		end else if (cfg_we) begin
			unique case (vta_pkg::reg_idx_t'(cfg_index))
				vta_pkg::REG_ROW0: row_q[0] <= cfg_data;
				vta_pkg::REG_ROW1: row_q[1] <= cfg_data;
				vta_pkg::REG_ROW2: row_q[2] <= cfg_data;
				vta_pkg::REG_ROW3: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: all products are formed side by side.
	logic                      vld_s1;
	vta_pkg::op_t              op_s1;
	logic signed [15:0]        a_s1 [3];
	logic signed [15:0]        b_s1 [3];
	logic signed [31:0]        tp_s1 [4][4];
	logic signed [31:0]        cr_s1 [6];
	logic signed [31:0]        dp_s1 [3];
	logic signed [31:0]        sq_s1 [3];
	logic signed [15:0]        av [4];

	assign av[0] = a_x;
	assign av[1] = a_y;
	assign av[2] = a_z;
	assign av[3] = a_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= vta_pkg::op_t'(operation);
			a_s1[0]  <= a_x;
			a_s1[1]  <= a_y;
			a_s1[2]  <= a_z;
			b_s1[0]  <= b_x;
			b_s1[1]  <= b_y;
			b_s1[2]  <= b_z;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					tp_s1[i][j] <= av[j] * $signed(row_q[i][16*j +: 16]);
				end
			end
			cr_s1[0] <= a_y * b_z;
			cr_s1[1] <= a_z * b_y;
			cr_s1[2] <= a_z * b_x;
			cr_s1[3] <= a_x * b_z;
			cr_s1[4] <= a_x * b_y;
			cr_s1[5] <= a_y * b_x;
			dp_s1[0] <= a_x * b_x;
			dp_s1[1] <= a_y * b_y;
			dp_s1[2] <= a_z * b_z;
			sq_s1[0] <= a_x * a_x;
			sq_s1[1] <= a_y * a_y;
			sq_s1[2] <= a_z * a_z;
		end
	end

	// Stage 2: sums and saturation for every operation but normalise; product sums are scaled.
	logic signed [SW-1:0] v [4];
	vta_pkg::sat_t        st [4];
	logic signed [SW-1:0] tsum [4];
	logic signed [SW-1:0] csum [3];
	logic signed [SW-1:0] dsum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tsum[i] = SW'(tp_s1[i][0]) + SW'(tp_s1[i][1]) + SW'(tp_s1[i][2])
				+ SW'(tp_s1[i][3]);
		end
		csum[0] = SW'(cr_s1[0]) - SW'(cr_s1[1]);
		csum[1] = SW'(cr_s1[2]) - SW'(cr_s1[3]);
		csum[2] = SW'(cr_s1[4]) - SW'(cr_s1[5]);
		dsum    = SW'(dp_s1[0]) + SW'(dp_s1[1]) + SW'(dp_s1[2]);
		for (int i = 0; i < 4; i++) begin
			v[i] = '0;
		end
		case (op_s1)
			vta_pkg::OP_TRANSFORM: begin
				for (int i = 0; i < 4; i++) begin
					v[i] = tsum[i] >>> FRAC_BITS;
				end
			end
			vta_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					v[i] = csum[i] >>> FRAC_BITS;
				end
			end
			vta_pkg::OP_DOT: v[0] = dsum >>> FRAC_BITS;
			vta_pkg::OP_SUB: begin
				for (int i = 0; i < 3; i++) begin
					v[i] = SW'(a_s1[i]) - SW'(b_s1[i]);
				end
			end
			vta_pkg::OP_ADD: begin
				for (int i = 0; i < 3; i++) begin
					v[i] = SW'(a_s1[i]) + SW'(b_s1[i]);
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			st[i] = vta_pkg::sat16(v[i]);
		end
	end

	// Search pipeline: index 0 is the stage 2 register.
	logic               vld_ss  [0:NST];
	vta_pkg::pass_t     pass_ss [0:NST];
	logic [2:0][PW-1:0] p_ss    [1:NST];
	logic [2:0][TW-1:0] t_ss    [1:NST];
	logic [2:0][MW-1:0] m_ss    [1:NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_ss[0] <= 1'b0;
		end else if (en) begin
			vld_ss[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_ss[0].op   <= op_s1;
			pass_ss[0].r    <= {st[3].val, st[2].val, st[1].val, st[0].val};
			pass_ss[0].ovf  <= st[0].ovf | st[1].ovf | st[2].ovf | st[3].ovf;
			pass_ss[0].len2 <= vta_pkg::LEN_W'(sq_s1[0][vta_pkg::SQ_W-1:0])
				+ vta_pkg::LEN_W'(sq_s1[1][vta_pkg::SQ_W-1:0])
				+ vta_pkg::LEN_W'(sq_s1[2][vta_pkg::SQ_W-1:0]);
			for (int c = 0; c < 3; c++) begin
				pass_ss[0].sq[c]  <= sq_s1[c][vta_pkg::SQ_W-1:0];
				pass_ss[0].neg[c] <= a_s1[c][15];
			end
		end
	end

	// One quotient bit per stage: try m | 2^B while keeping m*m*L and m*L current.
	for (genvar k = 0; k < NST; k++) begin : g_srch
		localparam int B = NST - 1 - k;
		logic [2:0][PW-1:0] p_in;
		logic [2:0][TW-1:0] t_in;
		logic [2:0][MW-1:0] m_in;
		logic [2:0][PW-1:0] p_nx;
		logic [2:0][TW-1:0] t_nx;
		logic [2:0][MW-1:0] m_nx;

		if (k == 0) begin : g_first
			assign p_in = '0;
			assign t_in = '0;
			assign m_in = '0;
		end else begin : g_rest
			assign p_in = p_ss[k];
			assign t_in = t_ss[k];
			assign m_in = m_ss[k];
		end

		always_comb begin
			logic [PW-1:0] cand;
			logic [PW-1:0] lim;
			for (int c = 0; c < 3; c++) begin
				cand = p_in[c] + (PW'(t_in[c]) << (B + 1))
					+ (PW'(pass_ss[k].len2) << (2 * B));
				lim  = PW'(pass_ss[k].sq[c]) << (2 * FRAC_BITS);
				if (cand <= lim) begin
					p_nx[c] = cand;
					t_nx[c] = t_in[c] + (TW'(pass_ss[k].len2) << B);
					m_nx[c] = m_in[c] | (MW'(1) << B);
				end else begin
					p_nx[c] = p_in[c];
					t_nx[c] = t_in[c];
					m_nx[c] = m_in[c];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_ss[k+1] <= 1'b0;
			end else if (en) begin
				vld_ss[k+1] <= vld_ss[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pass_ss[k+1] <= pass_ss[k];
				p_ss[k+1]    <= p_nx;
				t_ss[k+1]    <= t_nx;
				m_ss[k+1]    <= m_nx;
			end
		end
	end

	// Output stage: pick the normalise result or the one formed in stage 2.
	vta_pkg::pass_t fin;
	logic           fin_norm;
	logic           fin_zl;
	logic [15:0]    nr [3];

	assign fin      = pass_ss[NST];
	assign fin_norm = (fin.op == vta_pkg::OP_NORMALISE);
	assign fin_zl   = fin_norm && (fin.len2 == '0);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			nr[c] = fin.neg[c] ? (16'd0 - 16'(m_ss[NST][c])) : 16'(m_ss[NST][c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_ss[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (fin_zl) begin
				r_x <= '0;
				r_y <= '0;
				r_z <= '0;
				r_w <= '0;
				overflow <= 1'b0;
			end else if (fin_norm) begin
				r_x <= nr[0];
				r_y <= nr[1];
				r_z <= nr[2];
				r_w <= '0;
				overflow <= 1'b0;
			end else begin
				r_x <= fin.r[0];
				r_y <= fin.r[1];
				r_z <= fin.r[2];
				r_w <= fin.r[3];
				overflow <= fin.ovf;
			end
			zero_length <= fin_zl;
		end
	end

	// Checks.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(r_x) && $stable(r_w))
		else $error("result changed while stalled");

	a_zl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> r_x == 16'sd0 && r_y == 16'sd0 && r_z == 16'sd0)
		else $error("zero-length normalise gave a non-zero result");

	a_zl_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_length |-> !overflow)
		else $error("zero-length normalise flagged overflow");

endmodule
